>>> design/fsla_pkg.sv
// ----------------------------------------------------------------------------
// fsla_pkg: shared types and constants of the free list slot allocator
// Slot and link widths, command and status codes, register indexes and the
// structs that travel between the allocator modules.
// ----------------------------------------------------------------------------
package fsla_pkg;

	localparam int MAX_SLOTS   = 1024;
	localparam int CHUNK_BYTES = 4096;

	localparam int SLOT_W  = $clog2(MAX_SLOTS);
	localparam int LINK_W  = $clog2(MAX_SLOTS + 1);
	localparam int MEM_W   = LINK_W + 1;
	localparam int ADDR_W  = 32;
	localparam int ID_W    = 10;
	localparam int CFG_W   = 32;
	localparam int CNT_IN_W = 11;

	// End-of-list marker
	localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(MAX_SLOTS);

	// Register indexes
	localparam logic REG_SLOTS = 1'b0;
	localparam logic REG_BASE  = 1'b1;

	typedef enum logic {
		CMD_ALLOC   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_RANGE  = 2'd2,
		ST_DOUBLE = 2'd3
	} status_t;

	typedef enum logic {
		FS_IDLE = 1'b0,
		FS_EXEC = 1'b1
	} fsm_t;

	// Configuration view handed to the core
	typedef struct packed {
		logic              rebuild;
		logic [LINK_W-1:0] new_count;
		logic [LINK_W-1:0] count;
		logic [ADDR_W-1:0] base;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [ID_W-1:0]   slot_number;
		status_t           status;
	} res_t;

endpackage

>>> design/fsla_ram.sv
// ----------------------------------------------------------------------------
// fsla_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module fsla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/fsla_core.sv
// ----------------------------------------------------------------------------
// fsla_core: free list sequencer
// Reads the link entry of the head (allocate) or of the given slot (release),
// then updates head, fill count and the link memory in FS_EXEC once the result is taken.
// Entries at or above the fill count have never been handed out since the
// last rebuild and read as their rebuilt value: free, linked to the next slot.
// ----------------------------------------------------------------------------
module fsla_core
	import fsla_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  cmd_t            in_cmd,
	input  logic [ID_W-1:0] in_sid,
	output logic            res_valid,
	input  logic            res_ready,
	output res_t            res
);

	fsm_t              state_q, state_d;
	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] fill_q;
	cmd_t              cmd_s1;
	logic [SLOT_W-1:0] id_s1;
	logic [ID_W-1:0]   sid_s1;

	logic              rd_en;
	logic [SLOT_W-1:0] rd_addr;
	logic [MEM_W-1:0]  rd_data;
	logic              wr_en;
	logic [MEM_W-1:0]  wr_data;

	logic              virgin;
	logic [LINK_W-1:0] next_id;
	logic [LINK_W-1:0] ent_link;
	logic              ent_free;
	logic              commit;
	logic              head_none;
	logic              sid_range;

	fsla_ram #(
		.WIDTH (MEM_W),
		.DEPTH (MAX_SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (id_s1),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Resolve the entry: untouched slots read as the rebuilt chain
	always_comb begin
		virgin  = ({1'b0, id_s1} >= fill_q);
		next_id = {1'b0, id_s1} + LINK_W'(1);
		if (virgin) begin
			ent_free = 1'b1;
			ent_link = (next_id < cfg.count) ? next_id : NONE_LINK;
		end else begin
			ent_free = rd_data[MEM_W-1];
			ent_link = rd_data[LINK_W-1:0];
		end
		head_none = (head_q == NONE_LINK);
		sid_range = ({{(LINK_W > ID_W ? LINK_W - ID_W : 1){1'b0}}, sid_s1} >= cfg.count);
	end

	// Next state, read issue, result and write-back
	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		rd_en           = 1'b0;
		rd_addr         = (in_cmd == CMD_ALLOC) ? head_q[SLOT_W-1:0] : SLOT_W'(in_sid);
		res_valid       = 1'b0;
		commit          = 1'b0;
		wr_en           = 1'b0;
		wr_data         = {1'b0, NONE_LINK};
		res.status      = ST_OK;
		res.slot_number = '0;
		res.address     = '0;
		unique case (state_q)
			FS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					rd_en   = 1'b1;
					state_d = FS_EXEC;
				end
			end
			FS_EXEC: begin
				res_valid = 1'b1;
				commit    = res_ready;
				if (cmd_s1 == CMD_ALLOC) begin
					if (head_none) begin
						res.status = ST_EMPTY;
					end else begin
						res.slot_number = ID_W'(id_s1);
						res.address     = cfg.base + ADDR_W'(id_s1 * CHUNK_BYTES);
						wr_en           = commit;
						wr_data         = {1'b0, NONE_LINK};
					end
				end else begin
					if (sid_range) begin
						res.status = ST_RANGE;
					end else if (ent_free) begin
						res.status = ST_DOUBLE;
					end else begin
						res.slot_number = sid_s1;
						wr_en           = commit;
						wr_data         = {1'b1, head_q};
					end
				end
				if (commit) begin
					state_d = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Head pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (cfg.rebuild) begin
			head_q <= (cfg.new_count != '0) ? '0 : NONE_LINK;
			fill_q <= '0;
		end else if (wr_en) begin
			if (cmd_s1 == CMD_ALLOC) begin
				head_q <= ent_link;
				if (virgin) begin
					fill_q <= fill_q + LINK_W'(1);
				end
			end else begin
				head_q <= {1'b0, id_s1};
			end
		end
	end

	// Capture the item on accept
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cmd_s1 <= in_cmd;
			sid_s1 <= in_sid;
			id_s1  <= rd_addr;
		end
	end

	// Checks
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= NONE_LINK)
		else $error("head pointer beyond end-of-list marker");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LINK_W'(MAX_SLOTS))
		else $error("fill count beyond capacity");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (res_valid && !in_ready))
		else $error("accepted item did not reach execute");

	a_release_head: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && cmd_s1 == CMD_RELEASE && !cfg.rebuild)
			|=> (head_q == {1'b0, $past(id_s1)}))
		else $error("released slot did not become head");

	a_alloc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && cmd_s1 == CMD_ALLOC && !head_none)
			|-> (res.slot_number == ID_W'(head_q[SLOT_W-1:0])))
		else $error("allocated slot differs from head");

endmodule

>>> design/free_list_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// free_list_slot_allocator_top: LIFO free list of fixed-size slots
// Allocates and releases slots over stream channels, one result per item.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries commands: tuser is the command (0 allocate, 1 release),
//   tdata holds the slot to release. m_* returns one result per command:
//   status, slot number and byte address (base + slot * CHUNK_BYTES).
//   cfg_we/cfg_index/cfg_wdata write slots_in_use (index 0, saturates at
//   capacity, rebuilds the list) or base_address (index 1).
// Operation:
//   Each command first reads the link memory entry, then updates head and
//   memory and loads the result register. A new command is taken only
//   after the previous one has left execute; the result reaches m_tvalid
//   through the output register.
// Reset:
//   Clears the control state; the list then holds slots 0..count-1 in order,
//   all free. No clearing pass is needed: a fill count marks which memory
//   entries still hold their rebuilt value, so commands are taken at once.
// Stall:
//   A pending result is held in the output register; one more command may
//   be read, and its update waits until the output register frees.
// ----------------------------------------------------------------------------
module free_list_slot_allocator_top
	import fsla_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] slot_id
	input  logic        s_tuser,   // [0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [1:0] status, [11:2] slot_number, [43:12] address
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);

	logic [LINK_W-1:0]   count_q;
	logic [ADDR_W-1:0]   base_q;
	logic [CNT_IN_W-1:0] cnt_in;
	logic [LINK_W-1:0]   cnt_sat;
	cfg_t                cfg;
	logic                res_valid;
	logic                res_ready;
	res_t                res;
	logic                out_valid_q;
	res_t                out_q;

	// Saturate the written slot count at capacity
	always_comb begin
		cnt_in  = cfg_wdata[CNT_IN_W-1:0];
		cnt_sat = (int'(cnt_in) > MAX_SLOTS) ? NONE_LINK : LINK_W'(cnt_in);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= LINK_W'(MAX_SLOTS);
			base_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLOTS: count_q <= cnt_sat;
				REG_BASE:  base_q  <= cfg_wdata[ADDR_W-1:0];
				default:   ;
			endcase
		end
	end

	assign cfg.rebuild   = cfg_we && (cfg_index == REG_SLOTS);
	assign cfg.new_count = cnt_sat;
	assign cfg.count     = count_q;
	assign cfg.base      = base_q;

	fsla_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (cmd_t'(s_tuser)),
		.in_sid    (s_tdata[ID_W-1:0]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_q.address, out_q.slot_number, out_q.status};

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the free list slot allocator
// Drives allocate and release commands over the slave stream and checks every
// result on the master stream against a bit-accurate model of the LIFO free
// list. Sweeps slot counts and base addresses: empty and full lists, out of
// range ids, double frees, address wrap and list rebuilds while slots are held.
// Random gaps on the sender and random stalls on the receiver are included.
// ----------------------------------------------------------------------------
module tb
	import fsla_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int VIEW_CHK       = 0;   // model view that follows accepted items
	localparam int VIEW_GEN       = 1;   // model view that follows generated items
	localparam int RAND_PER_PHASE = 186;
	localparam int PRINT_CAP      = 200;

	typedef struct packed {
		cmd_t            cmd;
		logic [ID_W-1:0] sid;
	} cmd_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;     // [9:0] slot_id
	logic        s_tuser = 1'b0;   // [0] command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;          // [1:0] status, [11:2] slot_number, [43:12] address
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_wdata = '0;

	// Two copies of the allocator state: one checks, one steers stimulus
	logic [LINK_W-1:0] link_mem [2][MAX_SLOTS];
	bit                free_mem [2][MAX_SLOTS];
	logic [LINK_W-1:0] head_ptr [2];
	logic [LINK_W-1:0] count_reg [2];
	logic [ADDR_W-1:0] base_reg [2];

	cmd_item_t       cmd_backlog [$];
	res_t            pending_outcomes [$];
	logic [ID_W-1:0] held_slots [$];

	int issued_cnt = 0;
	int taken_cnt  = 0;
	int err_cnt    = 0;
	int gap_left   = 0;
	int stall_left = 0;
	bit send_idle  = 1'b1;
	bit recv_idle  = 1'b1;

	res_t      taken_res;
	res_t      got_res;
	res_t      want_res;
	cmd_item_t next_item;

	free_list_slot_allocator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Chain 0..count-1, all slots free
	function automatic void rebuild_view(input int view);
		for (int i = 0; i < MAX_SLOTS; i++) begin
			free_mem[view][i] = 1'b1;
			link_mem[view][i] = (i + 1 < count_reg[view]) ? LINK_W'(i + 1) : NONE_LINK;
		end
		head_ptr[view] = (count_reg[view] > 0) ? '0 : NONE_LINK;
	endfunction

	function automatic void set_reg(input int view, input logic idx, input logic [CFG_W-1:0] val);
		logic [LINK_W-1:0] v;
		if (idx == REG_SLOTS) begin
			v = val[CNT_IN_W-1:0];
			if (v > MAX_SLOTS)
				v = LINK_W'(MAX_SLOTS);
			count_reg[view] = v;
			rebuild_view(view);
		end else begin
			base_reg[view] = val;
		end
	endfunction

	// Pop or push one slot and return the result item the allocator owes
	function automatic res_t predict_outcome(input int view, input cmd_t cmd,
			input logic [ID_W-1:0] sid);
		res_t              r;
		logic [LINK_W-1:0] id;
		r = '0;
		r.status = ST_OK;
		if (cmd == CMD_ALLOC) begin
			id = head_ptr[view];
			if (id >= MAX_SLOTS) begin
				r.status = ST_EMPTY;
			end else begin
				head_ptr[view] = link_mem[view][id];
				free_mem[view][id] = 1'b0;
				link_mem[view][id] = NONE_LINK;
				r.slot_number = id[ID_W-1:0];
				r.address = base_reg[view] + ADDR_W'(id) * ADDR_W'(CHUNK_BYTES);
			end
		end else if ({1'b0, sid} >= count_reg[view]) begin
			r.status = ST_RANGE;
		end else if (free_mem[view][sid]) begin
			r.status = ST_DOUBLE;
		end else begin
			link_mem[view][sid] = head_ptr[view];
			free_mem[view][sid] = 1'b1;
			head_ptr[view] = LINK_W'(sid);
			r.slot_number = sid;
		end
		return r;
	endfunction

	// Queue one command and track which slots it leaves allocated
	function automatic void queue_cmd(input cmd_t cmd, input logic [ID_W-1:0] sid);
		res_t      r;
		cmd_item_t it;
		r = predict_outcome(VIEW_GEN, cmd, sid);
		if (r.status == ST_OK) begin
			if (cmd == CMD_ALLOC) begin
				held_slots.push_back(r.slot_number);
			end else begin
				for (int k = 0; k < held_slots.size(); k++) begin
					if (held_slots[k] == sid) begin
						held_slots.delete(k);
						break;
					end
				end
			end
		end
		it.cmd = cmd;
		it.sid = sid;
		cmd_backlog.push_back(it);
	endfunction

	// Mostly valid alloc/release traffic, some stray ids and double frees
	function automatic void queue_random(input int alloc_pct);
		int              r;
		int              cnt;
		logic [ID_W-1:0] sid;
		r = $urandom_range(99);
		cnt = count_reg[VIEW_GEN];
		if (r < 10) begin
			case ($urandom_range(2))
				0: begin
					sid = ID_W'($urandom_range(MAX_SLOTS - 1));
				end
				1: begin
					sid = ID_W'(cnt);
				end
				default: begin
					sid = ID_W'(cnt - 1);
				end
			endcase
			queue_cmd(CMD_RELEASE, sid);
		end else if (r < 14 && head_ptr[VIEW_GEN] != NONE_LINK) begin
			queue_cmd(CMD_RELEASE, head_ptr[VIEW_GEN][ID_W-1:0]);
		end else if (held_slots.size() == 0 || $urandom_range(99) < alloc_pct) begin
			queue_cmd(CMD_ALLOC, ID_W'($urandom));
		end else begin
			queue_cmd(CMD_RELEASE, held_slots[$urandom_range(held_slots.size() - 1)]);
		end
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		err_cnt++;
		if (err_cnt <= PRINT_CAP)
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
	endfunction

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		set_reg(VIEW_CHK, idx, val);
		set_reg(VIEW_GEN, idx, val);
		if (idx == REG_SLOTS)
			held_slots.delete();
	endtask

	// Hold until every queued item is accepted and answered
	task automatic wait_idle();
		while (cmd_backlog.size() != 0 || issued_cnt != taken_cnt
				|| pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Command driver: predict on acceptance, then load the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				taken_res = predict_outcome(VIEW_CHK, cmd_t'(s_tuser), s_tdata[ID_W-1:0]);
				pending_outcomes.push_back(taken_res);
				taken_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					next_item = cmd_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= next_item.cmd;
					s_tdata <= {{(16 - ID_W){1'b0}}, next_item.sid};
					issued_cnt++;
					gap_left = send_idle ? pick_gap() : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare against the oldest outcome, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_res = res_t'(m_tdata[ADDR_W+ID_W+1:0]);
				if (pending_outcomes.size() == 0) begin
					report_mismatch("unexpected result", '0, m_tdata[31:0]);
				end else begin
					want_res = pending_outcomes.pop_front();
					if (got_res.status !== want_res.status)
						report_mismatch("status", want_res.status, got_res.status);
					if (got_res.slot_number !== want_res.slot_number)
						report_mismatch("slot_number", want_res.slot_number,
							got_res.slot_number);
					if (got_res.address !== want_res.address)
						report_mismatch("address", want_res.address, got_res.address);
				end
			end
			if (recv_idle && stall_left == 0 && $urandom_range(99) < 25)
				stall_left = pick_gap();
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int cnt;
		set_reg(VIEW_CHK, REG_BASE, '0);
		set_reg(VIEW_GEN, REG_BASE, '0);
		set_reg(VIEW_CHK, REG_SLOTS, MAX_SLOTS);
		set_reg(VIEW_GEN, REG_SLOTS, MAX_SLOTS);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset list: pops in order, LIFO reuse, double free, top id
		queue_cmd(CMD_ALLOC, '0);
		queue_cmd(CMD_ALLOC, '1);
		queue_cmd(CMD_ALLOC, '0);
		queue_cmd(CMD_RELEASE, ID_W'(1));
		queue_cmd(CMD_RELEASE, ID_W'(1));
		queue_cmd(CMD_ALLOC, '0);
		queue_cmd(CMD_RELEASE, '1);
		queue_cmd(CMD_RELEASE, '0);
		queue_cmd(CMD_RELEASE, '0);
		wait_idle();

		// New base leaves the list alone; addresses wrap past 32 bits
		write_reg(REG_BASE, 32'hFFFF_F000);
		queue_cmd(CMD_ALLOC, '0);
		queue_cmd(CMD_ALLOC, '0);
		wait_idle();

		// Zero slots: every allocate is empty, every release out of range
		write_reg(REG_SLOTS, '0);
		queue_cmd(CMD_ALLOC, '1);
		queue_cmd(CMD_RELEASE, '0);
		queue_cmd(CMD_RELEASE, '1);
		wait_idle();

		// Count above capacity saturates
		write_reg(REG_SLOTS, 32'd2047);
		queue_cmd(CMD_ALLOC, '0);
		queue_cmd(CMD_RELEASE, '1);
		wait_idle();

		// Single slot: empty list, range edge, release and reuse
		write_reg(REG_SLOTS, 32'd1);
		write_reg(REG_BASE, 32'hFFFF_FFFF);
		queue_cmd(CMD_ALLOC, '0);
		queue_cmd(CMD_ALLOC, '0);
		queue_cmd(CMD_RELEASE, ID_W'(1));
		queue_cmd(CMD_RELEASE, '0);
		queue_cmd(CMD_RELEASE, '0);
		queue_cmd(CMD_ALLOC, '0);

		// Random phases over several slot counts and bases
		for (int p = 0; p < 8; p++) begin
			wait_idle();
			send_idle = (p % 4 == 0) || (p % 4 == 2);
			recv_idle = (p % 4 == 0) || (p % 4 == 1);
			case (p)
				0: cnt = MAX_SLOTS;
				1: cnt = 2;
				2: cnt = 1;
				3: cnt = 7;
				4: cnt = 33;
				5: cnt = 256;
				6: cnt = 1500;
				default: cnt = $urandom_range(1, MAX_SLOTS);
			endcase
			write_reg(REG_SLOTS, CFG_W'(cnt));
			write_reg(REG_BASE, (p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF_FFFF : $urandom);
			for (int n = 0; n < RAND_PER_PHASE / 2; n++)
				queue_random(70);
			// Drain fully, then on even phases rebuild the list while slots are held
			wait_idle();
			if (p % 2 == 0)
				write_reg(REG_SLOTS, CFG_W'(cnt));
			for (int n = 0; n < RAND_PER_PHASE / 2; n++)
				queue_random(35);
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
